// ===== hdl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants shared by the double-ended queue cells and top level.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP_BACK   = 2'd2,
        CMD_POP_FRONT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What a cell loads on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } cell_op_t;

endpackage

// ===== hdl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue of signed 32-bit values built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive command and push_value with start high; the beat is taken at any
//   edge where start is high and busy is low. busy stays low, so one command
//   is taken every cycle.
//   Each command gives one result beat in the next cycle: done is high for
//   exactly one cycle with pop_value, status and held_count. The receiver
//   cannot stall; it must take the result in that cycle.
//   Entries sit in a row of DEPTH cells with the front entry in cell 0.
//   Push front and pop front shift the whole row by one cell;
//   push back writes the cell at the current count, pop back reads the cell
//   just below it. Throughput 1 command per cycle.
//   A pop on an empty queue returns -1 with status empty; a push on a full
//   queue is dropped with status full. Neither changes the contents.
//   Reset empties the queue at once (count cleared); cell contents are not
//   cleared and are only read after being written.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                command,
    input  logic signed [DATA_W-1:0]  push_value,
    output logic                      done,
    output logic signed [DATA_W-1:0]  pop_value,
    output logic [1:0]                status,
    output logic [COUNT_W-1:0]        held_count
);

    cmd_t                     cmd;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic [COUNT_W-1:0]       last_pos;
    cell_op_t                 cell_op [DEPTH];
    logic signed [DATA_W-1:0] cell_value [DEPTH];

    logic                     done_reg;
    logic                     done_next;
    logic signed [DATA_W-1:0] pop_value_reg;
    logic signed [DATA_W-1:0] pop_value_next;
    status_t                  status_reg;
    status_t                  status_next;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign cmd      = cmd_t'(command);
    assign full     = (count_reg == COUNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign last_pos = count_reg - COUNT_W'(1);

    // Cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = push_value;
        end
        else
        begin : g_inner_l
            assign left_value = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner_r
            assign right_value = cell_value[i+1];
        end

        deq_cell u_cell (
            .clk         (clk),
            .op          (cell_op[i]),
            .push_value  (push_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i])
        );
    end

    // Per-cell control
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_op[i] = CELL_HOLD;
            if (accept)
            begin
                case (cmd)
                    CMD_PUSH_BACK:
                    begin
                        if (!full && count_reg == COUNT_W'(i))
                        begin
                            cell_op[i] = CELL_LOAD;
                        end
                    end
                    CMD_PUSH_FRONT:
                    begin
                        if (!full)
                        begin
                            cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (!empty)
                        begin
                            cell_op[i] = CELL_FROM_RIGHT;
                        end
                    end
                    default:
                    begin
                        cell_op[i] = CELL_HOLD;
                    end
                endcase
            end
        end
    end

    // Count and result beat
    always_comb
    begin
        count_next     = count_reg;
        done_next      = accept;
        pop_value_next = '0;
        status_next    = ST_OK;
        if (accept)
        begin
            case (cmd)
                CMD_PUSH_BACK, CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next    = ST_EMPTY;
                        pop_value_next = '1;
                    end
                    else
                    begin
                        pop_value_next = cell_value[last_pos[IDX_W-1:0]];
                        count_next     = last_pos;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next    = ST_EMPTY;
                        pop_value_next = '1;
                    end
                    else
                    begin
                        pop_value_next = cell_value[0];
                        count_next     = last_pos;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
    end

    assign done       = done_reg;
    assign pop_value  = pop_value_reg;
    assign status     = status_reg;
    assign held_count = count_reg;

endmodule

// ===== hdl/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue row: holds a value, or takes the new value or the
// value of either neighbor.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
(
    input  logic                     clk,
    input  cell_op_t                 op,
    input  logic signed [DATA_W-1:0] push_value,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic signed [DATA_W-1:0] right_value,
    output logic signed [DATA_W-1:0] value
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        case (op)
            CELL_HOLD:       value_next = value_reg;
            CELL_LOAD:       value_next = push_value;
            CELL_FROM_LEFT:  value_next = left_value;
            CELL_FROM_RIGHT: value_next = right_value;
            default:         value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== tb/tb_double_ended_queue_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// Self-checking bench for the double-ended queue: an in-bench shadow deque
// predicts every result beat, and a checker compares each one field by field.
// Directed tests cover empty pops, value extremes and the full-store drop;
// random traffic then swings the fill level between empty and full.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;

    import deq_pkg::*;

    localparam int CYCLE_LIMIT  = 60000;
    localparam int RANDOM_BEATS = 750;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        status_t                  status;
        logic [COUNT_W-1:0]       held_count;
    } deq_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                command;
    logic signed [DATA_W-1:0]  push_value;
    logic                      done;
    logic signed [DATA_W-1:0]  pop_value;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        held_count;

    // shadow of the queue contents, front entry first
    logic signed [DATA_W-1:0]  shadow_entries[$];
    deq_result_t               pending_results[$];

    int err_count;
    int cycle_count;
    int push_beats;
    int pop_beats;
    int empty_pops;
    int dropped_pushes;
    int peak_count;

    double_ended_queue_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .push_value (push_value),
        .done       (done),
        .pop_value  (pop_value),
        .status     (status),
        .held_count (held_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic deq_result_t deque_predict(cmd_t cmd,
                                                  logic signed [DATA_W-1:0] value);
        deq_result_t r;
        r.pop_value = '0;
        r.status    = ST_OK;
        if (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT)
        begin
            if (shadow_entries.size() >= DEPTH)
                r.status = ST_FULL;
            else if (cmd == CMD_PUSH_BACK)
                shadow_entries.push_back(value);
            else
                shadow_entries.push_front(value);
        end
        else
        begin
            if (shadow_entries.size() == 0)
            begin
                r.status    = ST_EMPTY;
                r.pop_value = '1;
            end
            else if (cmd == CMD_POP_BACK)
                r.pop_value = shadow_entries.pop_back();
            else
                r.pop_value = shadow_entries.pop_front();
        end
        r.held_count = COUNT_W'(shadow_entries.size());
        return r;
    endfunction

    function automatic void report_field(string field, logic [DATA_W-1:0] expected,
                                         logic [DATA_W-1:0] actual);
        if (actual !== expected)
        begin
            err_count++;
            $display("%0t: %s expected %0h actual %0h", $time, field, expected, actual);
        end
    endfunction

    // result beat checker: done is one cycle wide and cannot be held off
    always @(posedge clk)
    begin
        deq_result_t exp_beat;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: result beat with none pending, expected none actual done=%b",
                         $time, done);
            end
            else
            begin
                exp_beat = pending_results.pop_front();
                report_field("pop_value", exp_beat.pop_value, pop_value);
                report_field("status", DATA_W'(exp_beat.status), DATA_W'(status));
                report_field("held_count", DATA_W'(exp_beat.held_count),
                             DATA_W'(held_count));
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 11))
            0:       v = 32'sh7FFF_FFFF;
            1:       v = 32'sh8000_0000;
            2:       v = '0;
            3:       v = '1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // one command beat; start stays high so the next beat can follow at once
    task automatic send_beat(cmd_t cmd, logic signed [DATA_W-1:0] value);
        deq_result_t r;
        @(negedge clk);
        start      <= 1'b1;
        command    <= cmd;
        push_value <= value;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        r = deque_predict(cmd, value);
        pending_results.push_back(r);
        if (r.status == ST_FULL)
            dropped_pushes++;
        else if (r.status == ST_EMPTY)
            empty_pops++;
        else if (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT)
            push_beats++;
        else
            pop_beats++;
        if (int'(r.held_count) > peak_count)
            peak_count = int'(r.held_count);
    endtask

    // idle cycles with junk on the data inputs
    task automatic idle_gap(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start      <= 1'b0;
            command    <= 2'($urandom_range(0, 3));
            push_value <= $urandom;
        end
    endtask

    task automatic test_empty_pops();
        send_beat(CMD_POP_BACK, 32'sh1234_5678);
        send_beat(CMD_POP_FRONT, '1);
    endtask

    task automatic test_extreme_values();
        send_beat(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
        send_beat(CMD_PUSH_FRONT, 32'sh8000_0000);
        send_beat(CMD_PUSH_BACK, '0);
        send_beat(CMD_PUSH_FRONT, '1);
        idle_gap(2);
        send_beat(CMD_POP_FRONT, '0);
        send_beat(CMD_POP_BACK, '0);
    endtask

    // fill from both ends until the store is full, then push once more at each end
    task automatic test_fill_to_full();
        int i;
        for (i = shadow_entries.size(); i < DEPTH; i++)
        begin
            if (i[0])
                send_beat(CMD_PUSH_FRONT, 32'sh5555_5555 ^ i);
            else
                send_beat(CMD_PUSH_BACK, 32'shAAAA_AAAA ^ i);
        end
        send_beat(CMD_PUSH_BACK, 32'sh0BAD_F00D);
        send_beat(CMD_PUSH_FRONT, 32'sh7EAD_BEEF);
    endtask

    task automatic test_random_traffic(int beats);
        int   sent;
        int   burst;
        int   push_pct;
        int   i;
        cmd_t cmd;
        sent = 0;
        while (sent < beats)
        begin
            burst = $urandom_range(1, 40);
            // lean toward filling, draining or neither for this burst
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            for (i = 0; i < burst; i++)
            begin
                if ($urandom_range(1, 100) <= push_pct)
                    cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                else
                    cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
                send_beat(cmd, pick_value());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        command    = CMD_PUSH_BACK;
        push_value = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_pops();
        test_extreme_values();
        test_fill_to_full();
        test_random_traffic(RANDOM_BEATS);

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Beats checked: %0d pushes, %0d pops, %0d empty pops, %0d dropped pushes",
                 push_beats, pop_beats, empty_pops, dropped_pushes);
        $display("Fill level reached %0d of %0d entries", peak_count, DEPTH);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
